/* rtl/rrts_pkg.sv */
// Shared types and constants for the round-robin thread scheduler.
`default_nettype none

package rrts_pkg;

  localparam int MAX_THREADS = 16;
  localparam int TID_W       = 4;

  typedef logic [TID_W-1:0]       tid_t;
  typedef logic [MAX_THREADS-1:0] tmask_t;

  localparam tid_t IDLE_TID = 4'd0;

  localparam int OP_W = 3;

  typedef enum logic [OP_W-1:0] {
    OP_RESCHED = 3'd0,
    OP_BLOCK   = 3'd1,
    OP_UNBLOCK = 3'd2,
    OP_CREATE  = 3'd3,
    OP_DELETE  = 3'd4
  } op_t;

  typedef struct packed {
    tmask_t present;
    tmask_t blocked;
    tid_t   head;
    tid_t   tail;
    logic   nonempty;
    tid_t   runner;
  } sched_state_t;

  typedef struct packed {
    logic next_we;
    tid_t next_addr;
    tid_t next_data;
    logic prev_we;
    tid_t prev_addr;
    tid_t prev_data;
  } link_wr_t;

endpackage

`default_nettype wire

/* rtl/round_robin_thread_scheduler_core.sv */
// Top level of the round-robin thread scheduler.
`default_nettype none

// Each event transaction on s_* yields exactly one result transaction on m_*
// with the thread that runs afterwards and an error flag. The accept cycle
// reads the link memories; the execute state then updates the queue and writes
// the links back, and a new event is taken in the cycle after that update.
// The update waits while a previous result is still held on m_* and not taken.
// The link memories need no clearing after reset; events start right away.
// cfg_data sets scheduler_enable; write it only while no event is in flight.
module round_robin_thread_scheduler_core
  import rrts_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic       cfg_data,     // scheduler_enable
  input  wire logic       s_tvalid,
  output logic            s_tready,
  input  wire logic [7:0] s_tdata,      // [2:0] operation, [6:3] thread_id, [7] zero
  output logic            m_tvalid,
  input  wire logic       m_tready,
  output logic [7:0]      m_tdata       // [3:0] running_thread, [4] error, [7:5] zero
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EXEC = 2'b10
  } fsm_t;

  fsm_t         state;
  fsm_t         state_next;
  sched_state_t sched;
  sched_state_t sched_next;
  logic         enable;
  op_t          op;
  tid_t         id;
  tid_t         next_link;
  tid_t         prev_link;
  tid_t         next_rd_addr;
  link_wr_t     upd_wr;
  link_wr_t     mem_wr;
  logic         upd_err;
  logic         accept;
  logic         commit;
  op_t          in_op;
  tid_t         in_id;

  assign cfg_ready = !rst;
  assign s_tready  = (state == ST_IDLE) && !rst;
  assign accept    = s_tvalid && s_tready;
  assign commit    = (state == ST_EXEC) && (!m_tvalid || m_tready);

  assign in_op = op_t'(s_tdata[2:0]);
  assign in_id = s_tdata[6:3];

  // a deleted runner is not queued, so its event reads the head's link
  assign next_rd_addr = (in_op == OP_DELETE && in_id != sched.runner) ? in_id : sched.head;

  always_comb begin
    mem_wr         = upd_wr;
    mem_wr.next_we = upd_wr.next_we && commit;
    mem_wr.prev_we = upd_wr.prev_we && commit;
  end

  rrts_link_ram u_link_ram (
    .clk          (clk),
    .rd_en        (accept),
    .next_rd_addr (next_rd_addr),
    .prev_rd_addr (in_id),
    .next_rd_data (next_link),
    .prev_rd_data (prev_link),
    .wr           (mem_wr)
  );

  rrts_update u_update (
    .op        (op),
    .id        (id),
    .st        (sched),
    .enable    (enable),
    .next_link (next_link),
    .prev_link (prev_link),
    .st_next   (sched_next),
    .wr        (upd_wr),
    .err       (upd_err)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (commit) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state               <= ST_IDLE;
      enable              <= 1'b0;
      m_tvalid            <= 1'b0;
      sched.present       <= tmask_t'(1) << IDLE_TID;
      sched.blocked       <= '0;
      sched.head          <= '0;
      sched.tail          <= '0;
      sched.nonempty      <= 1'b0;
      sched.runner        <= IDLE_TID;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        enable <= cfg_data;
      end
      if (commit) begin
        sched    <= sched_next;
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op <= in_op;
      id <= in_id;
    end
    if (commit) begin
      m_tdata <= {3'b000, upd_err, sched_next.runner};
    end
  end

endmodule

`default_nettype wire

/* rtl/rrts_link_ram.sv */
// Next and previous link memories of the ready queue, synchronous read.
`default_nettype none

module rrts_link_ram
  import rrts_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rd_en,
  input  wire tid_t     next_rd_addr,
  input  wire tid_t     prev_rd_addr,
  output tid_t          next_rd_data,
  output tid_t          prev_rd_data,
  input  wire link_wr_t wr
);

  tid_t next_mem [MAX_THREADS];
  tid_t prev_mem [MAX_THREADS];

  always_ff @(posedge clk) begin
    if (wr.next_we) begin
      next_mem[wr.next_addr] <= wr.next_data;
    end
    if (wr.prev_we) begin
      prev_mem[wr.prev_addr] <= wr.prev_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      next_rd_data <= next_mem[next_rd_addr];
      prev_rd_data <= prev_mem[prev_rd_addr];
    end
  end

endmodule

`default_nettype wire

/* rtl/rrts_update.sv */
// Event update: next scheduler state, link writes and error flag.
`default_nettype none

module rrts_update
  import rrts_pkg::*;
(
  input  wire op_t          op,
  input  wire tid_t         id,
  input  wire sched_state_t st,
  input  wire logic         enable,
  input  wire tid_t         next_link,
  input  wire tid_t         prev_link,
  output sched_state_t      st_next,
  output link_wr_t          wr,
  output logic              err
);

  always_comb begin
    sched_state_t s;
    link_wr_t     w;
    tid_t         old_run;
    tid_t         nxt;
    logic         old_blk;
    logic         keep;
    logic         resched;

    s       = st;
    w       = '0;
    err     = 1'b0;
    old_run = st.runner;
    nxt     = st.runner;
    old_blk = 1'b0;
    keep    = 1'b0;
    resched = 1'b0;

    unique case (op)
      OP_RESCHED: begin
        resched = 1'b1;
        keep    = 1'b1;
        old_blk = st.blocked[old_run];
      end
      OP_BLOCK: begin
        if (old_run != IDLE_TID) begin
          s.blocked[old_run] = 1'b1;
        end
        resched = 1'b1;
        keep    = 1'b1;
        old_blk = s.blocked[old_run];
      end
      OP_UNBLOCK: begin
        if (!st.present[id]) begin
          err = 1'b1;
        end else if (st.blocked[id] && id != IDLE_TID) begin
          if (st.nonempty) begin
            w.prev_we   = 1'b1;
            w.prev_addr = st.head;
            w.prev_data = id;
            w.next_we   = 1'b1;
            w.next_addr = id;
            w.next_data = st.head;
          end else begin
            s.tail = id;
          end
          s.head        = id;
          s.nonempty    = 1'b1;
          s.blocked[id] = 1'b0;
        end
      end
      OP_CREATE: begin
        if (id == IDLE_TID || st.present[id]) begin
          err = 1'b1;
        end else begin
          s.present[id] = 1'b1;
          if (st.nonempty) begin
            w.next_we   = 1'b1;
            w.next_addr = st.tail;
            w.next_data = id;
            w.prev_we   = 1'b1;
            w.prev_addr = id;
            w.prev_data = st.tail;
          end else begin
            s.head = id;
          end
          s.tail        = id;
          s.nonempty    = 1'b1;
          s.blocked[id] = 1'b0;
        end
      end
      OP_DELETE: begin
        if (id == IDLE_TID || !st.present[id]) begin
          err = 1'b1;
        end else begin
          // unlink a queued thread
          if (!st.blocked[id] && id != old_run) begin
            if (st.head == id && st.tail == id) begin
              s.nonempty = 1'b0;
            end else begin
              if (st.head == id) begin
                s.head = next_link;
              end else begin
                w.next_we   = 1'b1;
                w.next_addr = prev_link;
                w.next_data = next_link;
              end
              if (st.tail == id) begin
                s.tail = prev_link;
              end else begin
                w.prev_we   = 1'b1;
                w.prev_addr = next_link;
                w.prev_data = prev_link;
              end
            end
          end
          s.present[id] = 1'b0;
          s.blocked[id] = 1'b0;
          if (id == old_run) begin
            resched = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase

    if (resched) begin
      priority if (!enable) begin
        nxt = IDLE_TID;
      end else if (s.nonempty) begin
        nxt = s.head;
        if (s.head == s.tail) begin
          s.nonempty = 1'b0;
        end else begin
          s.head = next_link;
        end
      end else if (keep && !old_blk) begin
        nxt = old_run;
      end else begin
        nxt = IDLE_TID;
      end
      s.runner = nxt;

      // append the preempted runner
      if (keep && old_run != nxt && !old_blk && old_run != IDLE_TID &&
          s.present[old_run]) begin
        if (s.nonempty) begin
          w.next_we   = 1'b1;
          w.next_addr = s.tail;
          w.next_data = old_run;
          w.prev_we   = 1'b1;
          w.prev_addr = old_run;
          w.prev_data = s.tail;
        end else begin
          s.head = old_run;
        end
        s.tail             = old_run;
        s.nonempty         = 1'b1;
        s.blocked[old_run] = 1'b0;
      end
    end

    st_next = s;
    wr      = w;
  end

endmodule

`default_nettype wire

/* rtl/rrts_checker.sv */
// Port-level checks of the scheduler core and their binding.
`default_nettype none

module rrts_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       s_tvalid,
  input wire logic       s_tready,
  input wire logic       m_tvalid,
  input wire logic       m_tready,
  input wire logic [7:0] m_tdata
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed");

  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("event accepted while another is in flight");

  a_result_follows_event: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(s_tvalid && s_tready, 2))
    else $error("result without a preceding event");

endmodule

bind round_robin_thread_scheduler_core rrts_checker u_rrts_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

`default_nettype wire
